// ===== hdl/dmsc_pkg.sv =====
package dmsc_pkg;

    // migration state codes
    localparam logic [2:0] ST_ERROR        = 3'd0;
    localparam logic [2:0] ST_STOP         = 3'd1;
    localparam logic [2:0] ST_RUNNING      = 3'd2;
    localparam logic [2:0] ST_STOP_COPY    = 3'd3;
    localparam logic [2:0] ST_RESUMING     = 3'd4;
    localparam logic [2:0] ST_RUNNING_P2P  = 3'd5;
    localparam logic [2:0] ST_PRE_COPY     = 3'd6;
    localparam logic [2:0] ST_PRE_COPY_P2P = 3'd7;

    // request types
    localparam logic [1:0] REQ_GET   = 2'd0;
    localparam logic [1:0] REQ_SET   = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;
    localparam logic [1:0] REQ_WRITE = 2'd3;

    // result status codes
    localparam logic [2:0] STS_OK          = 3'd0;
    localparam logic [2:0] STS_BAD_TARGET  = 3'd1;
    localparam logic [2:0] STS_WRONG_STATE = 3'd2;
    localparam logic [2:0] STS_TOO_LARGE   = 3'd3;
    localparam logic [2:0] STS_ARGSZ_SMALL = 3'd4;
    localparam logic [2:0] STS_SHORT_MSG   = 3'd5;

    localparam logic [31:0] MAX_XFER_RESET = 32'd1048576;
    localparam int unsigned MAX_STEPS      = 3;
    localparam int unsigned CMP_W          = 33;

    // allowed direct steps: bit t of entry f means f -> t
    localparam logic [7:0] ALLOWED_STEP [0:7] = '{
        8'b00000000, 8'b00011100, 8'b01000010, 8'b00000010,
        8'b00000010, 8'b00000000, 8'b00001100, 8'b00000000
    };

    // first hop on the shortest path [present][target], error means none
    localparam logic [2:0] PATH_NEXT [0:7][0:7] = '{
        '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
        '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd0, 3'd2, 3'd0},
        '{3'd0, 3'd1, 3'd2, 3'd1, 3'd1, 3'd0, 3'd6, 3'd0},
        '{3'd0, 3'd1, 3'd1, 3'd3, 3'd1, 3'd0, 3'd0, 3'd0},
        '{3'd0, 3'd1, 3'd1, 3'd1, 3'd4, 3'd0, 3'd1, 3'd0},
        '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
        '{3'd0, 3'd2, 3'd2, 3'd3, 3'd2, 3'd0, 3'd6, 3'd0},
        '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0}
    };

    // compare operand selection for the shared compare unit
    typedef enum logic [1:0] {
        CMP_LEN,
        CMP_SIZE,
        CMP_ARG
    } cmp_sel_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [3:0]  target_state;
        logic [31:0] xfer_size;
        logic [31:0] arg_size;
        logic [31:0] msg_len;
    } req_t;

    typedef struct packed {
        logic [2:0] cur_state;
        logic [2:0] status;
        logic       step_notify;
        logic       last;
    } rsp_t;

endpackage

// ===== hdl/device_migration_state_controller_top.sv =====
// channel  | ports                       | direction | payload
// request  | s_valid, s_ready, s_data    | in        | dmsc_pkg::req_t
// result   | m_valid, m_ready, m_data    | out       | dmsc_pkg::rsp_t
// config   | cfg_valid, cfg_ready, cfg_wdata | in    | max_xfer_size, 32 bits
//
// one request at a time; s_ready is high only while idle
// get: straight to the result; data request: length, size and argsz checks
// on the shared compare unit, then the result; set: a hop-by-hop path
// walk, then a load and a present per step beat, up to 3 beats
// aresetn is synchronous, active low; state resets to running, limit to 1 MiB
// a stalled result beat holds until m_ready; cfg_ready is always high
module device_migration_state_controller_top #(
    parameter int unsigned HEADER_BYTES = 8
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  dmsc_pkg::req_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output dmsc_pkg::rsp_t  m_data,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [31:0]     cfg_wdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LEN,
        S_SIZE,
        S_ARG,
        S_WALK,
        S_EMIT,
        S_OUT
    } fsm_t;

    fsm_t               state_reg;
    dmsc_pkg::req_t     req_reg;
    dmsc_pkg::rsp_t     rsp_reg;
    logic [2:0]         mig_state_reg;
    logic [31:0]        max_xfer_reg;
    logic [2:0]         walk_cur_reg;
    logic [1:0]         nsteps_reg;
    logic [1:0]         idx_reg;
    logic [2:0]         path_reg [0:dmsc_pkg::MAX_STEPS-1];

    dmsc_pkg::cmp_sel_t cmp_sel;
    logic               cmp_lt;
    logic               state_ok;
    logic               bad_target;
    logic [2:0]         hop;
    logic               hop_ok;

    // shared compare unit
    dmsc_cmp #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_cmp (
        .sel           (cmp_sel),
        .req           (req_reg),
        .max_xfer_size (max_xfer_reg),
        .lt            (cmp_lt)
    );

    always_comb begin
        case (state_reg)
            S_SIZE:  cmp_sel = dmsc_pkg::CMP_SIZE;
            S_ARG:   cmp_sel = dmsc_pkg::CMP_ARG;
            default: cmp_sel = dmsc_pkg::CMP_LEN;
        endcase
    end

    // data direction must match the migration phase
    assign state_ok = (req_reg.req_type == dmsc_pkg::REQ_READ) ?
                      (mig_state_reg == dmsc_pkg::ST_PRE_COPY ||
                       mig_state_reg == dmsc_pkg::ST_STOP_COPY) :
                      (mig_state_reg == dmsc_pkg::ST_RESUMING);

    // path walk lookups
    assign bad_target = req_reg.target_state[3] ||
                        (req_reg.target_state[2:0] == dmsc_pkg::ST_ERROR);
    assign hop        = dmsc_pkg::PATH_NEXT[walk_cur_reg][req_reg.target_state[2:0]];
    assign hop_ok     = (hop != dmsc_pkg::ST_ERROR) &&
                        dmsc_pkg::ALLOWED_STEP[walk_cur_reg][hop];

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = (state_reg == S_OUT);
    assign m_data    = rsp_reg;
    assign cfg_ready = 1'b1;

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            mig_state_reg <= dmsc_pkg::ST_RUNNING;
            max_xfer_reg  <= dmsc_pkg::MAX_XFER_RESET;
        end else begin
            if (cfg_valid && cfg_ready) begin
                max_xfer_reg <= cfg_wdata;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        req_reg             <= s_data;
                        walk_cur_reg        <= mig_state_reg;
                        nsteps_reg          <= '0;
                        idx_reg             <= '0;
                        rsp_reg.cur_state   <= mig_state_reg;
                        rsp_reg.status      <= dmsc_pkg::STS_OK;
                        rsp_reg.step_notify <= 1'b0;
                        rsp_reg.last        <= 1'b1;
                        case (s_data.req_type)
                            dmsc_pkg::REQ_GET: state_reg <= S_OUT;
                            dmsc_pkg::REQ_SET: state_reg <= S_WALK;
                            default:           state_reg <= S_LEN;
                        endcase
                    end
                end
                // message length, then phase
                S_LEN: begin
                    if (cmp_lt) begin
                        rsp_reg.status <= dmsc_pkg::STS_SHORT_MSG;
                        state_reg      <= S_OUT;
                    end else if (!state_ok) begin
                        rsp_reg.status <= dmsc_pkg::STS_WRONG_STATE;
                        state_reg      <= S_OUT;
                    end else begin
                        state_reg <= S_SIZE;
                    end
                end
                // transfer size against the limit
                S_SIZE: begin
                    if (cmp_lt) begin
                        rsp_reg.status <= dmsc_pkg::STS_TOO_LARGE;
                        state_reg      <= S_OUT;
                    end else begin
                        state_reg <= S_ARG;
                    end
                end
                // argsz must cover header and payload
                S_ARG: begin
                    if (cmp_lt) begin
                        rsp_reg.status <= dmsc_pkg::STS_ARGSZ_SMALL;
                    end
                    state_reg <= S_OUT;
                end
                // one hop of the shortest path per cycle
                S_WALK: begin
                    if (bad_target) begin
                        rsp_reg.status <= dmsc_pkg::STS_BAD_TARGET;
                        state_reg      <= S_OUT;
                    end else if (walk_cur_reg == req_reg.target_state[2:0]) begin
                        if (nsteps_reg == '0) begin
                            state_reg <= S_OUT;
                        end else begin
                            state_reg <= S_EMIT;
                        end
                    end else if (nsteps_reg == 2'(dmsc_pkg::MAX_STEPS) || !hop_ok) begin
                        rsp_reg.status <= dmsc_pkg::STS_BAD_TARGET;
                        state_reg      <= S_OUT;
                    end else begin
                        path_reg[nsteps_reg] <= hop;
                        nsteps_reg           <= nsteps_reg + 2'd1;
                        walk_cur_reg         <= hop;
                    end
                end
                // load the next step beat
                S_EMIT: begin
                    rsp_reg.cur_state   <= path_reg[idx_reg];
                    rsp_reg.status      <= dmsc_pkg::STS_OK;
                    rsp_reg.step_notify <= 1'b1;
                    rsp_reg.last        <= (idx_reg == nsteps_reg - 2'd1);
                    state_reg           <= S_OUT;
                end
                // present the beat; the last one commits the state
                S_OUT: begin
                    if (m_ready) begin
                        if (rsp_reg.last) begin
                            mig_state_reg <= rsp_reg.cur_state;
                            state_reg     <= S_IDLE;
                        end else begin
                            idx_reg   <= idx_reg + 2'd1;
                            state_reg <= S_EMIT;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // step beats always carry ok status
    a_step_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.step_notify |-> m_data.status == dmsc_pkg::STS_OK)
        else $error("step beat with error status");

    // a step never lands in error
    a_step_not_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.step_notify |-> m_data.cur_state != dmsc_pkg::ST_ERROR)
        else $error("step into error state");

    // request side closed while a result is out
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("request accepted while result pending");

    // final beat commits the reported state
    a_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_data.last |=> mig_state_reg == $past(m_data.cur_state))
        else $error("state not committed from final beat");

    // rejected or data beats leave the state alone
    a_no_change: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.step_notify |-> m_data.cur_state == mig_state_reg)
        else $error("non-step beat reports a different state");

endmodule

// ===== hdl/dmsc_cmp.sv =====
module dmsc_cmp #(
    parameter int unsigned HEADER_BYTES = 8
) (
    input  dmsc_pkg::cmp_sel_t sel,
    input  dmsc_pkg::req_t     req,
    input  logic [31:0]        max_xfer_size,
    output logic               lt
);

    logic [dmsc_pkg::CMP_W-1:0] op_a;
    logic [dmsc_pkg::CMP_W-1:0] op_b;
    logic [dmsc_pkg::CMP_W-1:0] hdr;

    assign hdr = dmsc_pkg::CMP_W'(HEADER_BYTES);

    // operand mux: length vs header, limit vs size, argsz vs header plus size
    always_comb begin
        case (sel)
            dmsc_pkg::CMP_LEN: begin
                op_a = {1'b0, req.msg_len};
                op_b = hdr;
            end
            dmsc_pkg::CMP_SIZE: begin
                op_a = {1'b0, max_xfer_size};
                op_b = {1'b0, req.xfer_size};
            end
            dmsc_pkg::CMP_ARG: begin
                op_a = {1'b0, req.arg_size};
                op_b = hdr + {1'b0, req.xfer_size};
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign lt = (op_a < op_b);

endmodule
